@@ rtl/core/gwc_pkg.sv @@
// Package for the grouped weighted centroid block.
// Holds the widths, codes and the queue item type shared by all modules.
// Depends on nothing.
`timescale 1ns / 1ps

package gwc_pkg;

    // Table size and the index width that follows from it.
    localparam int CLASSES   = 16;
    localparam int IDX_W     = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int OUT_SLOTS = 16;
    localparam int CNT_W     = $clog2(OUT_SLOTS + 1);

    // Field widths.
    localparam int KEY_W   = 32;
    localparam int COORD_W = 32;
    localparam int WGT_W   = 16;
    localparam int PROD_W  = COORD_W + WGT_W;
    localparam int SUM_W   = 64;
    localparam int SUMW_W  = 40;
    localparam int MEAN_W  = 32;
    localparam int STAT_W  = 2;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // Weight of 1.0 in Q8.8.
    localparam logic signed [WGT_W-1:0] WEIGHT_ONE = 16'sh0100;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_MEAN = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd3;

    // Commands.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_GROUPED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED = 2'd1;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic                      cmd;
        logic [KEY_W-1:0]          key;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [WGT_W-1:0]   w;
        logic                      neg;
    } gwc_item_t;

endpackage

@@ rtl/core/grouped_weighted_centroid.sv @@
// Grouped weighted centroid: an add item goes through the table accumulate
// path (key search and multiply, then saturating add and write) behind a
// two-entry queue, or is dropped for a negative weight or a full table. A
// finish item walks the table one entry a cycle; an entry that emits holds
// the walk for the 64-step x and y serial divider and the output. A finish
// with nothing to emit gives one empty result. Output is registered.
// Depends on gwc_pkg, gwc_front, gwc_queue and gwc_back.
`timescale 1ns / 1ps

module grouped_weighted_centroid (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [gwc_pkg::KEY_W-1:0]          class_key,
    input  logic signed [gwc_pkg::COORD_W-1:0] coord_x,
    input  logic signed [gwc_pkg::COORD_W-1:0] coord_y,
    input  logic signed [gwc_pkg::WGT_W-1:0]   weight,
    input  logic                               weight_ok,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gwc_pkg::MEAN_W-1:0]  mean_x,
    output logic signed [gwc_pkg::MEAN_W-1:0]  mean_y,
    output logic [gwc_pkg::KEY_W-1:0]          out_key,
    output logic [gwc_pkg::STAT_W-1:0]         status,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gwc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gwc_pkg::gwc_item_t push_item;
    gwc_pkg::gwc_item_t pop_item;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;

    // Classification front end.
    gwc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .class_key (class_key),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .weight    (weight),
        .weight_ok (weight_ok),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // Item queue.
    gwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    // Table and finish engine.
    gwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mean_x    (mean_x),
        .mean_y    (mean_y),
        .out_key   (out_key),
        .status    (status),
        .last      (last)
    );

endmodule

@@ rtl/core/gwc_front.sv @@
// Front end: configuration registers and classification of each input item.
// Resolves the effective key and weight and flags negative weights.
// Depends on gwc_pkg.
`timescale 1ns / 1ps

module gwc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [gwc_pkg::KEY_W-1:0]         class_key,
    input  logic signed [gwc_pkg::COORD_W-1:0] coord_x,
    input  logic signed [gwc_pkg::COORD_W-1:0] coord_y,
    input  logic signed [gwc_pkg::WGT_W-1:0]  weight,
    input  logic                              weight_ok,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gwc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              q_full,
    output logic                              q_push,
    output gwc_pkg::gwc_item_t                q_item
);

    logic                            grouped_reg;
    logic                            weighted_reg;
    logic signed [gwc_pkg::WGT_W-1:0] w_eff;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grouped_reg  <= 1'b0;
            weighted_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == gwc_pkg::REG_GROUPED)
            begin
                grouped_reg <= cfg_data[0];
            end
            if (cfg_index == gwc_pkg::REG_WEIGHTED)
            begin
                weighted_reg <= cfg_data[0];
            end
        end
    end

    assign cfg_ready = 1'b1;

    // Accept whenever the queue has room.
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Classification of the item.
    assign w_eff = (weighted_reg && weight_ok) ? weight : gwc_pkg::WEIGHT_ONE;

    always_comb
    begin
        q_item.cmd = cmd;
        q_item.key = grouped_reg ? class_key : '0;
        q_item.x   = coord_x;
        q_item.y   = coord_y;
        q_item.w   = w_eff;
        q_item.neg = w_eff[gwc_pkg::WGT_W-1];
    end

endmodule

@@ rtl/core/gwc_queue.sv @@
// Two-entry item queue between the front end and the back end.
// Depends on gwc_pkg.
`timescale 1ns / 1ps

module gwc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gwc_pkg::gwc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output gwc_pkg::gwc_item_t pop_item
);

    gwc_pkg::gwc_item_t slot_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/gwc_back.sv @@
// Back end: class table, accumulation, finish run with serial division,
// and the output register. Depends on gwc_pkg.
`timescale 1ns / 1ps

module gwc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  gwc_pkg::gwc_item_t                 q_item,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gwc_pkg::MEAN_W-1:0]  mean_x,
    output logic signed [gwc_pkg::MEAN_W-1:0]  mean_y,
    output logic [gwc_pkg::KEY_W-1:0]          out_key,
    output logic [gwc_pkg::STAT_W-1:0]         status,
    output logic                               last
);

    localparam int C  = gwc_pkg::CLASSES;
    localparam int IW = gwc_pkg::IDX_W;
    localparam int SW = gwc_pkg::SUM_W;
    localparam int WW = gwc_pkg::SUMW_W;
    localparam int PW = gwc_pkg::PROD_W;
    localparam int MW = gwc_pkg::MEAN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_SCAN,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                       state_reg;
    logic [C-1:0]                 valid_reg;
    logic [IW-1:0]                slot_reg;
    logic                         new_reg;
    logic [IW-1:0]                idx_reg;
    logic [gwc_pkg::CNT_W-1:0]    cnt_reg;
    logic                         last_reg;
    logic [gwc_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // Table payload.
    logic [gwc_pkg::KEY_W-1:0]    key_reg  [C];
    logic signed [SW-1:0]         swx_reg  [C];
    logic signed [SW-1:0]         swy_reg  [C];
    logic [WW-1:0]                sw_reg   [C];

    // Accumulation operands.
    logic [gwc_pkg::KEY_W-1:0]    akey_reg;
    logic signed [PW-1:0]         px_reg;
    logic signed [PW-1:0]         py_reg;
    logic [gwc_pkg::WGT_W-1:0]    aw_reg;

    // Divider state.
    logic [WW-1:0]                divisor_reg;
    logic [SW-1:0]                dvx_reg;
    logic [SW-1:0]                dvy_reg;
    logic [WW-1:0]                remx_reg;
    logic [WW-1:0]                remy_reg;
    logic                         negx_reg;
    logic                         negy_reg;

    logic                         out_free;
    logic                         out_load;
    logic [C-1:0]                 hit;
    logic [C-1:0]                 emit_mask;
    logic                         hit_any;
    logic                         free_any;
    logic [IW-1:0]                hit_idx;
    logic [IW-1:0]                free_idx;
    logic                         rest_any;
    logic                         later_any;
    logic signed [PW-1:0]         prod_x;
    logic signed [PW-1:0]         prod_y;
    logic signed [SW-1:0]         base_x;
    logic signed [SW-1:0]         base_y;
    logic [WW-1:0]                base_w;
    logic signed [SW-1:0]         acc_x;
    logic signed [SW-1:0]         acc_y;
    logic [WW-1:0]                acc_w;
    logic [WW:0]                  wsum;
    logic                         tbl_we;
    logic [WW:0]                  trial_x;
    logic [WW:0]                  trial_y;
    logic                         gex;
    logic                         gey;
    logic [MW-1:0]                qx;
    logic [MW-1:0]                qy;

    // Saturating signed add of a product onto a sum.
    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                     input logic signed [PW-1:0] b);
        logic signed [SW:0] s;
        begin
            s = {a[SW-1], a} + {{(SW-PW+1){b[PW-1]}}, b};
            if (s[SW] != s[SW-1])
            begin
                sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end
            else
            begin
                sat_add = s[SW-1:0];
            end
        end
    endfunction

    // Magnitude of a signed sum.
    function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] s);
        begin
            mag = s[SW-1] ? (~s + 1'b1) : s;
        end
    endfunction

    // Quotient to a signed 32-bit mean with saturation.
    function automatic logic [MW-1:0] to_mean(input logic [SW-1:0] q, input logic neg);
        begin
            if (neg)
            begin
                if (q > {{(SW-MW){1'b0}}, 1'b1, {(MW-1){1'b0}}})
                begin
                    to_mean = {1'b1, {(MW-1){1'b0}}};
                end
                else
                begin
                    to_mean = ~q[MW-1:0] + 1'b1;
                end
            end
            else if (q > {{(SW-MW+1){1'b0}}, {(MW-1){1'b1}}})
            begin
                to_mean = {1'b0, {(MW-1){1'b1}}};
            end
            else
            begin
                to_mean = q[MW-1:0];
            end
        end
    endfunction

    assign out_free = !out_valid || out_ready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty && out_free;

    // A new result is loaded into the output register this cycle.
    assign out_load = (q_pop && (q_item.cmd != gwc_pkg::CMD_FINISH) &&
                       (q_item.neg || (!hit_any && !free_any))) ||
                      ((state_reg == S_SCAN) && !rest_any && out_free) ||
                      ((state_reg == S_EMIT) && out_free);

    // Key search and emit mask over the table entries.
    always_comb
    begin
        hit_idx   = '0;
        free_idx  = '0;
        rest_any  = 1'b0;
        later_any = 1'b0;
        for (int i = C - 1; i >= 0; i--)
        begin
            hit[i]       = valid_reg[i] && (key_reg[i] == q_item.key);
            emit_mask[i] = valid_reg[i] && (sw_reg[i] != '0);
            if (hit[i])
            begin
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
        for (int i = 0; i < C; i++)
        begin
            if (emit_mask[i] && (IW'(i) >= idx_reg))
            begin
                rest_any = 1'b1;
            end
            if (emit_mask[i] && (IW'(i) > idx_reg))
            begin
                later_any = 1'b1;
            end
        end
        hit_any  = |hit;
        free_any = !(&valid_reg);
    end

    // Products for the accumulate cycle.
    assign prod_x = q_item.x * q_item.w;
    assign prod_y = q_item.y * q_item.w;

    // Saturating accumulation onto the chosen entry.
    always_comb
    begin
        base_x = new_reg ? '0 : swx_reg[slot_reg];
        base_y = new_reg ? '0 : swy_reg[slot_reg];
        base_w = new_reg ? '0 : sw_reg[slot_reg];
        acc_x  = sat_add(base_x, px_reg);
        acc_y  = sat_add(base_y, py_reg);
        wsum   = {1'b0, base_w} + {{(WW-gwc_pkg::WGT_W+1){1'b0}}, aw_reg};
        acc_w  = wsum[WW] ? {WW{1'b1}} : wsum[WW-1:0];
        tbl_we = (state_reg == S_ACC);
    end

    // One restoring division step for x and y.
    always_comb
    begin
        trial_x = {remx_reg, dvx_reg[SW-1]};
        trial_y = {remy_reg, dvy_reg[SW-1]};
        gex     = trial_x >= {1'b0, divisor_reg};
        gey     = trial_y >= {1'b0, divisor_reg};
        qx      = to_mean(dvx_reg, negx_reg);
        qy      = to_mean(dvy_reg, negy_reg);
    end

    // Table payload writes.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            key_reg[slot_reg] <= akey_reg;
            swx_reg[slot_reg] <= acc_x;
            swy_reg[slot_reg] <= acc_y;
            sw_reg[slot_reg]  <= acc_w;
        end
    end

    // Operand and divider registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            akey_reg <= q_item.key;
            px_reg   <= prod_x;
            py_reg   <= prod_y;
            aw_reg   <= q_item.w;
        end
        if ((state_reg == S_SCAN) && rest_any && emit_mask[idx_reg])
        begin
            divisor_reg <= sw_reg[idx_reg];
            dvx_reg     <= mag(swx_reg[idx_reg]);
            dvy_reg     <= mag(swy_reg[idx_reg]);
            negx_reg    <= swx_reg[idx_reg][SW-1];
            negy_reg    <= swy_reg[idx_reg][SW-1];
            remx_reg    <= '0;
            remy_reg    <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            remx_reg <= gex ? WW'(trial_x - {1'b0, divisor_reg}) : trial_x[WW-1:0];
            remy_reg <= gey ? WW'(trial_y - {1'b0, divisor_reg}) : trial_y[WW-1:0];
            dvx_reg  <= {dvx_reg[SW-2:0], gex};
            dvy_reg  <= {dvy_reg[SW-2:0], gey};
        end
    end

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            slot_reg    <= '0;
            new_reg     <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            div_cnt_reg <= '0;
            out_valid   <= 1'b0;
            mean_x      <= '0;
            mean_y      <= '0;
            out_key     <= '0;
            status      <= gwc_pkg::ST_MEAN;
            last        <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && !out_load)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_item.cmd == gwc_pkg::CMD_FINISH)
                        begin
                            idx_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                        else if (q_item.neg || (!hit_any && !free_any))
                        begin
                            out_valid <= 1'b1;
                            mean_x    <= '0;
                            mean_y    <= '0;
                            out_key   <= q_item.key;
                            status    <= q_item.neg ? gwc_pkg::ST_NEG : gwc_pkg::ST_FULL;
                            last      <= 1'b0;
                        end
                        else
                        begin
                            slot_reg  <= hit_any ? hit_idx : free_idx;
                            new_reg   <= !hit_any;
                            state_reg <= S_ACC;
                        end
                    end
                end
                S_ACC:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    state_reg           <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (!rest_any)
                    begin
                        // Nothing left to emit in a run that emitted nothing.
                        if (out_free)
                        begin
                            out_valid <= 1'b1;
                            mean_x    <= '0;
                            mean_y    <= '0;
                            out_key   <= '0;
                            status    <= gwc_pkg::ST_NONE;
                            last      <= 1'b1;
                            valid_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (emit_mask[idx_reg])
                    begin
                        last_reg    <= !later_any ||
                                       (cnt_reg == gwc_pkg::CNT_W'(gwc_pkg::OUT_SLOTS - 1));
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == gwc_pkg::DIV_CNT_W'(SW - 1))
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid <= 1'b1;
                        mean_x    <= qx;
                        mean_y    <= qy;
                        out_key   <= key_reg[idx_reg];
                        status    <= gwc_pkg::ST_MEAN;
                        last      <= last_reg;
                        cnt_reg   <= cnt_reg + 1'b1;
                        if (last_reg)
                        begin
                            valid_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/gwc_checker.sv @@
// Port-level checks for the grouped weighted centroid block, bound to the top.
// Depends on gwc_pkg and grouped_weighted_centroid.
`timescale 1ns / 1ps

module gwc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [gwc_pkg::MEAN_W-1:0]  mean_x,
    input logic signed [gwc_pkg::MEAN_W-1:0]  mean_y,
    input logic [gwc_pkg::KEY_W-1:0]          out_key,
    input logic [gwc_pkg::STAT_W-1:0]         status,
    input logic                               last
);

    // A stalled result holds its status.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
        else $error("stalled result changed");

    // An empty finish result is the last one and carries zeros.
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gwc_pkg::ST_NONE |->
        last && mean_x == 0 && mean_y == 0 && out_key == 0)
        else $error("empty finish result malformed");

    // Dropped vertices are never the end of a run and carry zero means.
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == gwc_pkg::ST_NEG || status == gwc_pkg::ST_FULL) |->
        !last && mean_x == 0 && mean_y == 0)
        else $error("drop result malformed");

    // No result is shown straight after reset.
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind grouped_weighted_centroid gwc_checker u_checker (.*);

@@ sim/grouped_weighted_centroid_tb.sv @@
// Self-checking testbench for grouped_weighted_centroid: directed table, then random phases.
// Expected results come from a behavioral copy of the class table kept in this file.
// Depends on gwc_pkg and the grouped_weighted_centroid RTL.
`timescale 1ns / 1ps

module grouped_weighted_centroid_tb;

    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_WAIT  = 200;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_ITEMS  = 130;
    localparam logic [gwc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef struct {
        logic [gwc_pkg::MEAN_W-1:0] mx;
        logic [gwc_pkg::MEAN_W-1:0] my;
        logic [gwc_pkg::KEY_W-1:0]  key;
        logic [gwc_pkg::STAT_W-1:0] st;
        logic                       lst;
    } centroid_t;

    typedef struct {
        logic                      op;
        logic [gwc_pkg::KEY_W-1:0] key;
        logic [31:0]               x;
        logic [31:0]               y;
        logic [15:0]               w;
        logic                      ok;
        bit                        set_regs;
        bit                        reg_g;
        bit                        reg_w;
        bit                        typed;
        centroid_t                 res;
    } vertex_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = gwc_pkg::CMD_ADD;
    logic [gwc_pkg::KEY_W-1:0] class_key = '0;
    logic signed [gwc_pkg::COORD_W-1:0] coord_x = '0;
    logic signed [gwc_pkg::COORD_W-1:0] coord_y = '0;
    logic signed [gwc_pkg::WGT_W-1:0] weight = '0;
    logic weight_ok = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [gwc_pkg::MEAN_W-1:0] mean_x;
    logic signed [gwc_pkg::MEAN_W-1:0] mean_y;
    logic [gwc_pkg::KEY_W-1:0] out_key;
    logic [gwc_pkg::STAT_W-1:0] status;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gwc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gwc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the block's registers and class table.
    bit          mdl_grouped;
    bit          mdl_weighted;
    bit          tbl_valid [gwc_pkg::CLASSES];
    logic [31:0] tbl_key [gwc_pkg::CLASSES];
    longint      tbl_wx [gwc_pkg::CLASSES];
    longint      tbl_wy [gwc_pkg::CLASSES];
    logic [39:0] tbl_w [gwc_pkg::CLASSES];

    centroid_t   centroid_q [$];
    int          errors = 0;
    int          cycles = 0;
    int          n_results = 0;
    int          n_finish = 0;
    int          n_neg = 0;
    int          n_full = 0;
    bit          steady_out = 0;
    int          stall_left = 0;

    grouped_weighted_centroid u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .class_key(class_key), .coord_x(coord_x), .coord_y(coord_y),
        .weight(weight), .weight_ok(weight_ok),
        .out_valid(out_valid), .out_ready(out_ready),
        .mean_x(mean_x), .mean_y(mean_y), .out_key(out_key), .status(status),
        .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, centroid_q.size());
            $display("grouped_weighted_centroid regression: fail");
            $finish;
        end
    end

    // Output back-pressure: mostly short stalls, a few long ones.
    always @(posedge clk)
    begin
        if (steady_out || stall_left == 0)
        begin
            out_ready <= 1'b1;
            if (!steady_out && $urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                           : $urandom_range(1, 3);
        end
        else
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
    end

    // Compare each accepted result with the oldest expected centroid.
    always @(posedge clk)
    begin
        centroid_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (centroid_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result key %h status %0d", $time, out_key, status);
            end
            else
            begin
                e = centroid_q.pop_front();
                if (mean_x !== e.mx || mean_y !== e.my || out_key !== e.key ||
                    status !== e.st || last !== e.lst)
                begin
                    errors++;
                    $display("%0t: mismatch expected x %h y %h key %h st %0d last %0b",
                             $time, e.mx, e.my, e.key, e.st, e.lst);
                    $display("%0t:          actual   x %h y %h key %h st %0d last %0b",
                             $time, mean_x, mean_y, out_key, status, last);
                end
            end
        end
    end

    function automatic logic [31:0] quotient(longint s, logic [39:0] w);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        q = mag / {24'd0, w};
        if (s < 0)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

    function automatic centroid_t make_res(logic [31:0] mx, logic [31:0] my,
                                           logic [31:0] key, logic [1:0] st, logic lst);
        centroid_t r;
        r.mx = mx;
        r.my = my;
        r.key = key;
        r.st = st;
        r.lst = lst;
        return r;
    endfunction

    // Predicts the centroids an accepted item causes and updates the table copy.
    task automatic predict_centroids(input vertex_row_t v, output centroid_t res [$]);
        logic [31:0] k;
        longint      wt;
        int          slot;
        logic [40:0] tw;
        res = {};
        if (v.op == gwc_pkg::CMD_FINISH)
        begin
            n_finish++;
            for (int i = 0; i < gwc_pkg::CLASSES; i++)
                if (tbl_valid[i] && tbl_w[i] != 0 && res.size() < gwc_pkg::OUT_SLOTS)
                    res.push_back(make_res(quotient(tbl_wx[i], tbl_w[i]),
                                           quotient(tbl_wy[i], tbl_w[i]),
                                           tbl_key[i], gwc_pkg::ST_MEAN, 1'b0));
            if (res.size() == 0)
                res.push_back(make_res('0, '0, '0, gwc_pkg::ST_NONE, 1'b1));
            else
                res[res.size()-1].lst = 1'b1;
            foreach (tbl_valid[i])
                tbl_valid[i] = 0;
            return;
        end
        k = mdl_grouped ? v.key : '0;
        wt = (mdl_weighted && v.ok) ? longint'($signed(v.w))
                                    : longint'(gwc_pkg::WEIGHT_ONE);
        if (wt < 0)
        begin
            n_neg++;
            res.push_back(make_res('0, '0, k, gwc_pkg::ST_NEG, 1'b0));
            return;
        end
        slot = -1;
        for (int i = 0; i < gwc_pkg::CLASSES; i++)
            if (slot < 0 && tbl_valid[i] && tbl_key[i] == k)
                slot = i;
        if (slot < 0)
        begin
            for (int i = 0; i < gwc_pkg::CLASSES; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
            if (slot < 0)
            begin
                n_full++;
                res.push_back(make_res('0, '0, k, gwc_pkg::ST_FULL, 1'b0));
                return;
            end
            tbl_valid[slot] = 1;
            tbl_key[slot] = k;
            tbl_wx[slot] = 0;
            tbl_wy[slot] = 0;
            tbl_w[slot] = '0;
        end
        tbl_wx[slot] = sat_sum(tbl_wx[slot], longint'($signed(v.x)) * wt);
        tbl_wy[slot] = sat_sum(tbl_wy[slot], longint'($signed(v.y)) * wt);
        tw = {1'b0, tbl_w[slot]} + 41'(wt);
        tbl_w[slot] = tw[40] ? 40'hFF_FFFF_FFFF : tw[39:0];
    endtask

    // Drives one item, waits for acceptance, then leaves a random gap.
    task automatic send_vertex(input vertex_row_t v, input bit no_gap);
        centroid_t res [$];
        int gap;
        in_valid <= 1'b1;
        cmd <= v.op;
        class_key <= v.key;
        coord_x <= v.x;
        coord_y <= v.y;
        weight <= v.w;
        weight_ok <= v.ok;
        do
            @(posedge clk);
        while (!in_ready);
        predict_centroids(v, res);
        if (v.typed)
            res = '{v.res};
        foreach (res[i])
            centroid_q.push_back(res[i]);
        gap = 0;
        if (!no_gap && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every expected result has come out.
    task automatic drain;
        in_valid <= 1'b0;
        while (centroid_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Writes both registers and the unused index while the block is idle.
    task automatic write_regs(input bit g, input bit w);
        logic [gwc_pkg::CFG_IDX_W-1:0] idx [3];
        logic [gwc_pkg::CFG_DATA_W-1:0] dat [3];
        idx = '{gwc_pkg::REG_GROUPED, gwc_pkg::REG_WEIGHTED, REG_SPARE};
        dat = '{{31'($urandom()), g}, {31'($urandom()), w}, $urandom()};
        drain();
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= dat[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        mdl_grouped = g;
        mdl_weighted = w;
    endtask

    function automatic vertex_row_t add_row(logic [31:0] key, logic [31:0] x, logic [31:0] y,
                                            logic [15:0] w, logic ok);
        vertex_row_t r;
        r = '{default: '0};
        r.op = gwc_pkg::CMD_ADD;
        r.key = key;
        r.x = x;
        r.y = y;
        r.w = w;
        r.ok = ok;
        return r;
    endfunction

    function automatic vertex_row_t finish_row();
        vertex_row_t r;
        r = add_row($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(0, 1));
        r.op = gwc_pkg::CMD_FINISH;
        return r;
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 16'h8000 | 16'($urandom());
            1: return 16'h0000;
            2: return 16'h7FFF;
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Stimulus.
    initial
    begin
        vertex_row_t rows [$];
        vertex_row_t r;
        logic [31:0] pool [];
        int sent;
        int n;
        bit g;
        bit w;
        int ph;

        // Directed table.
        r = finish_row();
        r.typed = 1;
        r.res = make_res('0, '0, '0, gwc_pkg::ST_NONE, 1'b1);
        rows.push_back(r);
        rows.push_back(add_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 1'b1));
        r = finish_row();
        r.typed = 1;
        r.res = make_res(32'h7FFF_FFFF, 32'h8000_0000, '0, gwc_pkg::ST_MEAN, 1'b1);
        rows.push_back(r);
        r = add_row(32'd5, 32'h0000_0100, 32'hFFFF_FF00, 16'h8000, 1'b1);
        r.set_regs = 1;
        r.reg_g = 1;
        r.reg_w = 1;
        r.typed = 1;
        r.res = make_res('0, '0, 32'd5, gwc_pkg::ST_NEG, 1'b0);
        rows.push_back(r);
        rows.push_back(add_row(32'd5, 32'h0000_0100, 32'h0000_0200, 16'h0000, 1'b1));
        r = finish_row();
        r.typed = 1;
        r.res = make_res('0, '0, '0, gwc_pkg::ST_NONE, 1'b1);
        rows.push_back(r);
        // Fill all sixteen entries, then one new key overflows the table.
        for (int i = 0; i < gwc_pkg::CLASSES; i++)
            rows.push_back(add_row(i == 0 ? 32'hFFFF_FFFF : i, rand_coord(), rand_coord(),
                                   (i % 3 == 0) ? 16'h7FFF : (i % 3 == 1) ? 16'($urandom())
                                                                           : 16'h0001,
                                   i % 3 != 1));
        r = add_row(32'h1234_5678, $urandom(), $urandom(), 16'h0100, 1'b1);
        r.typed = 1;
        r.res = make_res('0, '0, 32'h1234_5678, gwc_pkg::ST_FULL, 1'b0);
        rows.push_back(r);
        rows.push_back(finish_row());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].set_regs)
                write_regs(rows[i].reg_g, rows[i].reg_w);
            send_vertex(rows[i], 1'b0);
        end

        // Random phases: each one picks a setting and a key pool, then ends with a finish.
        sent = 0;
        ph = 0;
        while (sent < RAND_ITEMS)
        begin
            g = (ph < 4) ? ph[0] : $urandom_range(0, 1);
            w = (ph < 4) ? ph[1] : $urandom_range(0, 1);
            write_regs(g, w);
            steady_out = (ph % 5 == 2);
            pool = new[$urandom_range(2, 20)];
            foreach (pool[i])
                pool[i] = ($urandom_range(0, 7) == 0) ? (i % 2 ? 32'hFFFF_FFFF : 32'h0)
                                                      : $urandom();
            n = $urandom_range(10, 30);
            for (int j = 0; j < n; j++)
            begin
                if (j == n - 1 || $urandom_range(0, 9) == 0)
                    r = finish_row();
                else
                    r = add_row(($urandom_range(0, 15) == 0) ? $urandom()
                                                             : pool[$urandom_range(0, pool.size()-1)],
                                rand_coord(), rand_coord(), rand_weight(),
                                $urandom_range(0, 5) != 0);
                send_vertex(r, ph % 5 == 2);
                sent++;
                // Now and then hold off until the block has emptied.
                if ($urandom_range(0, 40) == 0)
                    drain();
            end
            ph++;
        end

        drain();
        $display("Covered %0d finish runs, %0d results, %0d negative weights, %0d full table drops",
                 n_finish, n_results, n_neg, n_full);
        $display("across %0d register settings with random gaps on both sides.", ph + 2);
        if (errors == 0)
            $display("grouped_weighted_centroid regression: pass");
        else
            $display("grouped_weighted_centroid regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/gwc_pkg.sv
rtl/core/gwc_front.sv
rtl/core/gwc_queue.sv
rtl/core/gwc_back.sv
rtl/core/grouped_weighted_centroid.sv
rtl/core/gwc_checker.sv
sim/grouped_weighted_centroid_tb.sv
